// File: sv/jkse_pkg.sv
// Package for the JSON key string extractor: constants, types and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package jkse_pkg;

  // Sizes
  localparam int KEY_MAX_BYTES = 32;
  localparam int CAPACITY_MAX  = 4096;
  localparam int KEY_IDX_W     = 5;
  localparam int KEY_LEN_W     = 6;
  localparam int CAP_W         = 13;
  localparam int CNT_W         = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int KEY_BITS      = KEY_MAX_BYTES * 8;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_LVL_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 3'd5;

  // Register reset values
  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST     = 6'd4;
  localparam logic [CAP_W-1:0]     VALUE_CAPACITY_RST = 13'd256;

  // Scan phases
  localparam logic [3:0] PH_PLAIN   = 4'd0;
  localparam logic [3:0] PH_MATCH   = 4'd1;
  localparam logic [3:0] PH_SKIP    = 4'd2;
  localparam logic [3:0] PH_SKIPESC = 4'd3;
  localparam logic [3:0] PH_WS1     = 4'd4;
  localparam logic [3:0] PH_WS2     = 4'd5;
  localparam logic [3:0] PH_VALUE   = 4'd6;
  localparam logic [3:0] PH_VESC    = 4'd7;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  // Saturated configuration seen by the scanner
  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_len;
    logic [KEY_BITS-1:0]  key_bytes;
    logic [CAP_W-1:0]     cap;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       search_done;
    logic       key_found;
  } result_t;

  // Results pushed by one step, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Queue status back to the scanner
  typedef struct packed {
    logic [RES_LVL_W-1:0] level;
  } fifo_st_t;

  // Scanner status
  typedef struct packed {
    logic       fire;
    logic       done;
    logic [3:0] phase;
  } scan_st_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage
`default_nettype wire

// File: sv/jkse_if.sv
// Stream interfaces for the text input channel and the result channel.
`timescale 1ns / 1ps
`default_nettype none
interface jkse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

interface jkse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       value_valid;
  logic       search_done;
  logic       key_found;

  modport source (output valid, output value_byte, output value_valid,
                  output search_done, output key_found, input ready);
  modport sink (input valid, input value_byte, input value_valid,
                input search_done, input key_found, output ready);
endinterface
`default_nettype wire

// File: sv/json_key_string_extractor_core.sv
// Top level of the JSON key string extractor.
// Path: an accepted text byte is held in the input register; its results are written into
// the result queue once the queue has room for two, and the output shows the queue head.
// Throughput: one text byte per cycle while the queue has room for two results; a byte that
// gives two results (value byte and done) is absorbed by the four-entry result queue.
// Reset: synchronous active-low rst_n clears scan state, input register, queue and
// restores register defaults (key length 4, key bytes 0, capacity 256).
`timescale 1ns / 1ps
`default_nettype none
module json_key_string_extractor_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  jkse_in_if.sink                              in_ch,
  jkse_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jkse_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  jkse_pkg::cfg_t     cfg;
  jkse_pkg::push_t    push;
  jkse_pkg::fifo_st_t fifo_st;
  jkse_pkg::scan_st_t scan_st;

  jkse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jkse_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .fifo_st (fifo_st),
    .push    (push),
    .scan_st (scan_st)
  );

  jkse_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .fifo_st (fifo_st),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  // queue never overflows
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.level <= jkse_pkg::RES_LVL_W'(jkse_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // a push of two results only happens with room for two
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (fifo_st.level <= jkse_pkg::RES_LVL_W'(jkse_pkg::RES_DEPTH - 2)))
    else $error("double push without room");

  // a finished search returns the scanner to plain text
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_st.fire && scan_st.done) |=> (scan_st.phase == jkse_pkg::PH_PLAIN))
    else $error("search not cleared after done");
`endif

endmodule
`default_nettype wire

// File: sv/jkse_cfg_regs.sv
// Configuration registers with saturation of key length and capacity.
`timescale 1ns / 1ps
`default_nettype none
module jkse_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [jkse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jkse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output jkse_pkg::cfg_t                      cfg
);

  logic [jkse_pkg::KEY_LEN_W-1:0] key_length_r;
  logic [jkse_pkg::CFG_DATA_W-1:0] key_bytes_r [4];
  logic [jkse_pkg::CAP_W-1:0]     value_capacity_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r     <= jkse_pkg::KEY_LENGTH_RST;
      key_bytes_r[0]   <= '0;
      key_bytes_r[1]   <= '0;
      key_bytes_r[2]   <= '0;
      key_bytes_r[3]   <= '0;
      value_capacity_r <= jkse_pkg::VALUE_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jkse_pkg::CFG_KEY_LENGTH: begin
          key_length_r <= cfg_wdata[jkse_pkg::KEY_LEN_W-1:0];
        end
        jkse_pkg::CFG_KEY_BYTES_0: key_bytes_r[0] <= cfg_wdata;
        jkse_pkg::CFG_KEY_BYTES_1: key_bytes_r[1] <= cfg_wdata;
        jkse_pkg::CFG_KEY_BYTES_2: key_bytes_r[2] <= cfg_wdata;
        jkse_pkg::CFG_KEY_BYTES_3: key_bytes_r[3] <= cfg_wdata;
        jkse_pkg::CFG_VALUE_CAPACITY: begin
          value_capacity_r <= cfg_wdata[jkse_pkg::CAP_W-1:0];
        end
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Saturated view
  always_comb begin
    cfg.key_len = (key_length_r > jkse_pkg::KEY_LEN_W'(jkse_pkg::KEY_MAX_BYTES)) ?
                  jkse_pkg::KEY_LEN_W'(jkse_pkg::KEY_MAX_BYTES) : key_length_r;
    cfg.key_bytes = {key_bytes_r[3], key_bytes_r[2], key_bytes_r[1], key_bytes_r[0]};
    cfg.cap = (value_capacity_r > jkse_pkg::CAP_W'(jkse_pkg::CAPACITY_MAX)) ?
              jkse_pkg::CAP_W'(jkse_pkg::CAPACITY_MAX) : value_capacity_r;
  end

endmodule
`default_nettype wire

// File: sv/jkse_scan.sv
// Input register and per-byte scan state machine.
`timescale 1ns / 1ps
`default_nettype none
module jkse_scan (
  input  wire logic       clk,
  input  wire logic       rst_n,
  jkse_in_if.sink         in_ch,
  input  wire jkse_pkg::cfg_t     cfg,
  input  wire jkse_pkg::fifo_st_t fifo_st,
  output jkse_pkg::push_t  push,
  output jkse_pkg::scan_st_t scan_st
);

  // Input register
  logic       ireg_valid_r;
  logic [7:0] ibyte_r;
  logic       ilast_r;

  // Scan state
  logic [3:0]                     phase_r, phase_nxt;
  logic [jkse_pkg::KEY_LEN_W-1:0] kidx_r, kidx_nxt;
  logic [jkse_pkg::CNT_W-1:0]     vcnt_r, vcnt_nxt;
  logic                           fin_r, fin_nxt;

  logic                           room, fire, is_end;
  logic                           emit, done, found;
  logic [7:0]                     emit_byte;
  logic [7:0]                     key_b;
  logic [jkse_pkg::CNT_W-1:0]     vinc;
  logic [7:0]                     kbit;

  // Room for two results in the queue
  assign room = fifo_st.level <= jkse_pkg::RES_LVL_W'(jkse_pkg::RES_DEPTH - 2);
  assign fire = ireg_valid_r && room;
  assign in_ch.ready = !ireg_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ireg_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      ireg_valid_r <= 1'b1;
    end else if (fire) begin
      ireg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ibyte_r <= in_ch.text_byte;
      ilast_r <= in_ch.text_last;
    end
  end

  // Expected key byte
  assign kbit  = {kidx_r[jkse_pkg::KEY_IDX_W-1:0], 3'b000};
  assign key_b = cfg.key_bytes[kbit +: 8];
  assign vinc  = vcnt_r + jkse_pkg::CNT_W'(1);
  assign is_end = ilast_r || (ibyte_r == jkse_pkg::CH_NUL);

  // Step logic for one byte
  always_comb begin
    phase_nxt = phase_r;
    kidx_nxt  = kidx_r;
    vcnt_nxt  = vcnt_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    emit_byte = ibyte_r;
    done      = 1'b0;
    found     = 1'b0;

    if (fin_r) begin
      // waiting for the end of the text
      if (is_end) begin
        fin_nxt   = 1'b0;
        phase_nxt = jkse_pkg::PH_PLAIN;
        kidx_nxt  = '0;
        vcnt_nxt  = '0;
      end
    end else if (cfg.cap == '0) begin
      done = is_end;
    end else if (ibyte_r == jkse_pkg::CH_NUL) begin
      // zero byte ends the text; a pending backslash goes out literally
      emit      = (phase_r == jkse_pkg::PH_VESC);
      emit_byte = jkse_pkg::CH_BSL;
      done      = 1'b1;
      found     = (phase_r == jkse_pkg::PH_VALUE) || (phase_r == jkse_pkg::PH_VESC);
    end else begin
      unique case (phase_r)
        jkse_pkg::PH_PLAIN: begin
          if (ibyte_r == jkse_pkg::CH_QUOTE) begin
            phase_nxt = jkse_pkg::PH_MATCH;
            kidx_nxt  = '0;
          end
        end
        jkse_pkg::PH_MATCH, jkse_pkg::PH_SKIP: begin
          if ((phase_r == jkse_pkg::PH_MATCH) && (kidx_r < cfg.key_len) &&
              (ibyte_r == key_b)) begin
            kidx_nxt = kidx_r + jkse_pkg::KEY_LEN_W'(1);
          end else if ((phase_r == jkse_pkg::PH_MATCH) && (kidx_r >= cfg.key_len) &&
                       (ibyte_r == jkse_pkg::CH_QUOTE)) begin
            phase_nxt = jkse_pkg::PH_WS1;
          end else if (ibyte_r == jkse_pkg::CH_QUOTE) begin
            phase_nxt = jkse_pkg::PH_PLAIN;
          end else if (ibyte_r == jkse_pkg::CH_BSL) begin
            phase_nxt = jkse_pkg::PH_SKIPESC;
          end else begin
            phase_nxt = jkse_pkg::PH_SKIP;
          end
        end
        jkse_pkg::PH_SKIPESC: phase_nxt = jkse_pkg::PH_SKIP;
        jkse_pkg::PH_WS1: begin
          priority if (jkse_pkg::is_ws(ibyte_r)) begin
          end else if (ibyte_r == jkse_pkg::CH_COLON) begin
            phase_nxt = jkse_pkg::PH_WS2;
          end else if (ibyte_r == jkse_pkg::CH_QUOTE) begin
            phase_nxt = jkse_pkg::PH_MATCH;
            kidx_nxt  = '0;
          end else begin
            phase_nxt = jkse_pkg::PH_PLAIN;
          end
        end
        jkse_pkg::PH_WS2: begin
          priority if (jkse_pkg::is_ws(ibyte_r)) begin
          end else if (ibyte_r == jkse_pkg::CH_QUOTE) begin
            vcnt_nxt  = '0;
            phase_nxt = jkse_pkg::PH_VALUE;
            if (cfg.cap <= jkse_pkg::CAP_W'(1)) begin
              done  = 1'b1;
              found = 1'b1;
            end
          end else begin
            phase_nxt = jkse_pkg::PH_PLAIN;
          end
        end
        jkse_pkg::PH_VALUE, jkse_pkg::PH_VESC: begin
          if ((phase_r == jkse_pkg::PH_VALUE) && (ibyte_r == jkse_pkg::CH_QUOTE)) begin
            done  = 1'b1;
            found = 1'b1;
          end else if ((phase_r == jkse_pkg::PH_VALUE) && (ibyte_r == jkse_pkg::CH_BSL) &&
                       !ilast_r) begin
            phase_nxt = jkse_pkg::PH_VESC;
          end else begin
            // value byte, escapes undone
            if (phase_r == jkse_pkg::PH_VESC) begin
              priority if (ibyte_r == jkse_pkg::CH_N) emit_byte = jkse_pkg::CH_LF;
              else if (ibyte_r == jkse_pkg::CH_R) emit_byte = jkse_pkg::CH_CR;
              else if (ibyte_r == jkse_pkg::CH_T) emit_byte = jkse_pkg::CH_TAB;
              else emit_byte = ibyte_r;
              phase_nxt = jkse_pkg::PH_VALUE;
            end
            emit     = 1'b1;
            vcnt_nxt = vinc;
            if (({1'b0, vinc} + jkse_pkg::CAP_W'(1)) >= cfg.cap) begin
              done  = 1'b1;
              found = 1'b1;
            end
          end
        end
        default: phase_nxt = jkse_pkg::PH_PLAIN;
      endcase
      // end of text closes the search
      if (is_end && !done) begin
        done  = 1'b1;
        found = (phase_nxt == jkse_pkg::PH_VALUE) || (phase_nxt == jkse_pkg::PH_VESC);
      end
    end

    if (done) begin
      phase_nxt = jkse_pkg::PH_PLAIN;
      kidx_nxt  = '0;
      vcnt_nxt  = '0;
      fin_nxt   = !is_end;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jkse_pkg::PH_PLAIN;
      kidx_r  <= '0;
      vcnt_r  <= '0;
      fin_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      kidx_r  <= kidx_nxt;
      vcnt_r  <= vcnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Results to the queue: value byte first, then the done mark
  always_comb begin
    push.n = fire ? ({1'b0, emit} + {1'b0, done}) : 2'd0;
    push.r0.value_byte  = emit ? emit_byte : 8'h00;
    push.r0.value_valid = emit;
    push.r0.search_done = !emit;
    push.r0.key_found   = !emit && found;
    push.r1.value_byte  = 8'h00;
    push.r1.value_valid = 1'b0;
    push.r1.search_done = 1'b1;
    push.r1.key_found   = found;
  end

  assign scan_st.fire  = fire;
  assign scan_st.done  = done;
  assign scan_st.phase = phase_r;

endmodule
`default_nettype wire

// File: sv/jkse_out_fifo.sv
// Four-entry result queue, up to two pushes and one pop per cycle.
`timescale 1ns / 1ps
`default_nettype none
module jkse_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jkse_pkg::push_t push,
  output jkse_pkg::fifo_st_t    fifo_st,
  jkse_out_if.source           out_ch
);

  jkse_pkg::result_t              res_q_r [jkse_pkg::RES_DEPTH];
  logic [jkse_pkg::RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [jkse_pkg::RES_LVL_W-1:0] level_r, level_nxt;
  logic                           pop;

  assign pop     = out_ch.valid && out_ch.ready;
  assign wr_ptr1 = wr_ptr_r + jkse_pkg::RES_PTR_W'(1);
  assign level_nxt = level_r + jkse_pkg::RES_LVL_W'(push.n)
                   - jkse_pkg::RES_LVL_W'(pop);

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) res_q_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) res_q_r[wr_ptr1] <= push.r1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + jkse_pkg::RES_PTR_W'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + jkse_pkg::RES_PTR_W'(1);
      level_r <= level_nxt;
    end
  end

  assign fifo_st.level = level_r;

  // Head of the queue
  assign out_ch.valid       = level_r != '0;
  assign out_ch.value_byte  = res_q_r[rd_ptr_r].value_byte;
  assign out_ch.value_valid = res_q_r[rd_ptr_r].value_valid;
  assign out_ch.search_done = res_q_r[rd_ptr_r].search_done;
  assign out_ch.key_found   = res_q_r[rd_ptr_r].key_found;

endmodule
`default_nettype wire
